### hw/rtl/zsa_pkg.sv
// Package for the sliding-window z-score anomaly block: sizes, limits, codes and types.
// No dependencies; every other file of the block imports it.
package zsa_pkg;

    localparam int WINDOW_DEPTH = 32;
    localparam int NUM_CH       = 4;
    localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int RAW_W        = 10;
    localparam int XW           = 12;
    localparam int CFG_W        = 16;
    localparam int MIN_W        = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CH_W         = 2;

    // accepted samples stay within -640..1583, square below 2^22
    localparam int SUM_W  = XW + $clog2(WINDOW_DEPTH);
    localparam int SQ_W   = 22 + $clog2(WINDOW_DEPTH) + 1;
    localparam int DIFF_W = XW + 1;
    localparam int DQ_W   = 2 * DIFF_W;

    localparam int NX_W   = CNT_W + 1 + XW;
    localparam int SS_W   = 2 * SUM_W;
    localparam int NQ_W   = CNT_W + 1 + SQ_W;
    localparam int D_W    = NX_W + 1;
    localparam int V_W    = CNT_W + SQ_W;
    localparam int VS_W   = ((NQ_W > SS_W) ? NQ_W : SS_W) + 1;
    localparam int DD_W   = 2 * D_W;
    localparam int PT_W   = CFG_W + V_W;
    localparam int PLO_W  = PT_W / 2;
    localparam int PHI_W  = PT_W - PLO_W;
    localparam int LHS_W  = DD_W + 16;
    localparam int RHS_W  = 2 * CFG_W + V_W + 1;
    localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;

    localparam logic [CFG_IDX_W-1:0] CFG_Z_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_Z_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FILL      = 2'd2;

    localparam logic [CFG_W-1:0] Z_THRESHOLD_RST   = 16'd768;
    localparam logic [CFG_W-1:0] SCORE_Z_LIMIT_RST = 16'd1051;
    localparam logic [MIN_W-1:0] MIN_FILL_RST      = 8'd10;

    localparam logic [RAW_W-1:0] RAW_DISC_LOW  = 10'd5;
    localparam logic [RAW_W-1:0] RAW_DISC_HIGH = 10'd1018;
    localparam logic signed [XW-1:0] TEMP_DISC_LOW  = -12'sd800;
    localparam logic signed [XW-1:0] TEMP_DISC_HIGH = 12'sd1280;
    localparam logic signed [XW-1:0] TEMP_MIN       = -12'sd640;
    localparam logic signed [XW-1:0] TEMP_MAX       = 12'sd1120;
    localparam logic signed [XW-1:0] HUM_DISC_LOW   = 12'sd16;
    localparam logic signed [XW-1:0] HUM_DISC_HIGH  = 12'sd1584;
    localparam logic signed [XW-1:0] HUM_MIN        = 12'sd0;
    localparam logic signed [XW-1:0] HUM_MAX        = 12'sd1600;

    typedef struct packed {
        logic [RAW_W-1:0]     moisture;
        logic signed [XW-1:0] temperature;
        logic signed [XW-1:0] humidity;
        logic [RAW_W-1:0]     light;
    } zsa_entry_t;

    typedef struct packed {
        logic done;
        logic over_thr;
        logic over_lim;
    } zsa_zres_t;

    typedef struct packed {
        logic              disconnected;
        logic              out_of_range;
        logic              accepted;
        logic              enough_data;
        logic [NUM_CH-1:0] anomaly;
        logic              combined_anomaly;
        logic              sensor_fault;
    } zsa_result_t;

endpackage

### hw/rtl/zsa_if.sv
// Channel interfaces of the z-score anomaly block: readings, results, configuration writes.
// Depends on zsa_pkg.
interface zsa_in_if import zsa_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [RAW_W-1:0]     moisture_sample;
    logic signed [XW-1:0] temperature_sample;
    logic signed [XW-1:0] humidity_sample;
    logic [RAW_W-1:0]     light_sample;

    modport source (output valid, moisture_sample, temperature_sample, humidity_sample,
                    light_sample, input ready);
    modport sink (input valid, moisture_sample, temperature_sample, humidity_sample,
                  light_sample, output ready);
endinterface

interface zsa_out_if;
    logic valid;
    logic ready;
    logic disconnected;
    logic out_of_range;
    logic accepted;
    logic enough_data;
    logic moisture_anomaly;
    logic temperature_anomaly;
    logic humidity_anomaly;
    logic light_anomaly;
    logic combined_anomaly;
    logic sensor_fault;

    modport source (output valid, disconnected, out_of_range, accepted, enough_data,
                    moisture_anomaly, temperature_anomaly, humidity_anomaly, light_anomaly,
                    combined_anomaly, sensor_fault, input ready);
    modport sink (input valid, disconnected, out_of_range, accepted, enough_data,
                  moisture_anomaly, temperature_anomaly, humidity_anomaly, light_anomaly,
                  combined_anomaly, sensor_fault, output ready);
endinterface

interface zsa_cfg_if import zsa_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/zsa_window_mem.sv
// Ring window store: one 44-bit entry of four samples per slot, registered read.
// Depends on zsa_pkg.
module zsa_window_mem import zsa_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_addr,
    input  zsa_entry_t        wr_data,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_addr,
    output zsa_entry_t        rd_data
);

    zsa_entry_t mem [WINDOW_DEPTH];
    zsa_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/zsa_ztest.sv
// Five-stage z-test for one channel: D = n*x - S, V = n*Q - S*S, then
// D*D*65536 against T*T*V for both limits. Depends on zsa_pkg.
module zsa_ztest import zsa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [CNT_W-1:0]       n,
    input  logic signed [XW-1:0]   x,
    input  logic signed [SUM_W-1:0] s,
    input  logic signed [SQ_W-1:0] q,
    input  logic [CFG_W-1:0]       thr,
    input  logic [CFG_W-1:0]       lim,
    output zsa_zres_t              res
);

    logic [4:0] vld_reg;

    logic signed [NX_W-1:0]  nx_reg;
    logic signed [SS_W-1:0]  ss_reg;
    logic signed [NQ_W-1:0]  nq_reg;
    logic signed [SUM_W-1:0] s1_reg;

    logic signed [D_W-1:0] d_reg;
    logic [V_W-1:0]        v_reg;

    logic [DD_W-1:0] dd_reg;
    logic [PT_W-1:0] pt_reg;
    logic [PT_W-1:0] pl_reg;
    logic            vz_reg;

    logic [DD_W-1:0]        dd4_reg;
    logic                   vz4_reg;
    logic [CFG_W+PLO_W-1:0] rtl_reg;
    logic [CFG_W+PHI_W-1:0] rth_reg;
    logic [CFG_W+PLO_W-1:0] rll_reg;
    logic [CFG_W+PHI_W-1:0] rlh_reg;

    logic over_thr_reg;
    logic over_lim_reg;

    logic signed [NX_W-1:0]  nx_w;
    logic signed [SS_W-1:0]  ss_w;
    logic signed [NQ_W-1:0]  nq_w;
    logic signed [D_W-1:0]   d_w;
    logic signed [VS_W-1:0]  vs_w;
    logic [V_W-1:0]          v_w;
    logic [D_W-1:0]          mag_w;
    logic [DD_W-1:0]         dd_w;
    logic [PT_W-1:0]         pt_w;
    logic [PT_W-1:0]         pl_w;
    logic [CFG_W+PLO_W-1:0]  rtl_w;
    logic [CFG_W+PHI_W-1:0]  rth_w;
    logic [CFG_W+PLO_W-1:0]  rll_w;
    logic [CFG_W+PHI_W-1:0]  rlh_w;
    logic [CMP_W-1:0]        lhs_w;
    logic [CMP_W-1:0]        rhs_t_w;
    logic [CMP_W-1:0]        rhs_l_w;

    assign nx_w  = $signed({1'b0, n}) * x;
    assign ss_w  = s * s;
    assign nq_w  = $signed({1'b0, n}) * q;

    assign d_w   = D_W'(nx_reg) - D_W'(s1_reg);
    assign vs_w  = VS_W'(nq_reg) - VS_W'(ss_reg);
    assign v_w   = (vs_w > 0) ? vs_w[V_W-1:0] : '0;

    assign mag_w = d_reg[D_W-1] ? -d_reg : d_reg;
    assign dd_w  = mag_w * mag_w;
    assign pt_w  = thr * v_reg;
    assign pl_w  = lim * v_reg;

    // T*T*V split over two half-width products of the registered T*V
    assign rtl_w = thr * pt_reg[PLO_W-1:0];
    assign rth_w = thr * pt_reg[PT_W-1:PLO_W];
    assign rll_w = lim * pl_reg[PLO_W-1:0];
    assign rlh_w = lim * pl_reg[PT_W-1:PLO_W];

    assign lhs_w   = CMP_W'({dd4_reg, 16'b0});
    assign rhs_t_w = (CMP_W'(rth_reg) << PLO_W) + CMP_W'(rtl_reg);
    assign rhs_l_w = (CMP_W'(rlh_reg) << PLO_W) + CMP_W'(rll_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nx_reg <= nx_w;
            ss_reg <= ss_w;
            nq_reg <= nq_w;
            s1_reg <= s;
        end
        if (vld_reg[0])
        begin
            d_reg <= d_w;
            v_reg <= v_w;
        end
        if (vld_reg[1])
        begin
            dd_reg <= dd_w;
            pt_reg <= pt_w;
            pl_reg <= pl_w;
            vz_reg <= (v_reg == '0);
        end
        if (vld_reg[2])
        begin
            dd4_reg <= dd_reg;
            vz4_reg <= vz_reg;
            rtl_reg <= rtl_w;
            rth_reg <= rth_w;
            rll_reg <= rll_w;
            rlh_reg <= rlh_w;
        end
        if (vld_reg[3])
        begin
            over_thr_reg <= !vz4_reg && (lhs_w > rhs_t_w);
            over_lim_reg <= !vz4_reg && (lhs_w > rhs_l_w);
        end
    end

    assign res.done     = vld_reg[4];
    assign res.over_thr = over_thr_reg;
    assign res.over_lim = over_lim_reg;

endmodule

### hw/rtl/sliding_window_zscore_anomaly_top.sv
// Sliding-window z-score anomaly detector, top level.
// A rejected reading goes straight to the result; an accepted one first updates the sums of the
// four channels, and if it reaches the sample threshold each channel then passes in turn through
// the shared z-test before the result loads. One reading at a time: the next is taken
// the cycle after the result loads; an unaccepted result holds the next one.
// rst_n clears control, counts and sums, sets config defaults; window memory needs no clearing.
module sliding_window_zscore_anomaly_top import zsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    zsa_in_if.sink     sample,
    zsa_out_if.source  result,
    zsa_cfg_if.sink    cfg
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_UPD  = 2'd1;
    localparam logic [1:0] ST_CALC = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    logic [CFG_W-1:0] z_threshold_reg;
    logic [CFG_W-1:0] score_z_limit_reg;
    logic [MIN_W-1:0] min_fill_reg;

    logic [SLOT_W-1:0] write_slot_reg;
    logic [CNT_W-1:0]  count_reg;
    logic signed [SUM_W-1:0] sum_reg [NUM_CH];
    logic signed [SQ_W-1:0]  sq_reg  [NUM_CH];

    logic signed [XW-1:0] x_reg [NUM_CH];
    logic                 disc_reg;
    logic                 oor_reg;
    logic                 enough_reg;
    logic [NUM_CH-1:0]    an_reg;
    logic                 comb_reg;
    logic [CH_W-1:0]      ch_reg;
    logic                 zstart_reg;

    zsa_result_t out_reg;
    logic        out_valid_reg;

    logic in_xfer;
    logic out_xfer;
    logic disc_w;
    logic oor_w;
    logic full_w;
    logic [CNT_W-1:0] need_w;
    logic [CNT_W-1:0] count_inc_w;

    zsa_entry_t old_w;
    zsa_entry_t new_w;
    logic signed [XW-1:0]     old_ch_w;
    logic signed [XW-1:0]     x_ch_w;
    logic signed [DIFF_W-1:0] dsum_w;
    logic signed [DIFF_W-1:0] psum_w;
    logic signed [DQ_W-1:0]   dq_w;
    zsa_zres_t zres;

    assign in_xfer  = sample.valid && sample.ready;
    assign out_xfer = result.valid && result.ready;
    assign sample.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    assign disc_w = (sample.moisture_sample <= RAW_DISC_LOW)
                 || (sample.moisture_sample >= RAW_DISC_HIGH)
                 || (sample.temperature_sample <= TEMP_DISC_LOW)
                 || (sample.temperature_sample >= TEMP_DISC_HIGH)
                 || (sample.humidity_sample <= HUM_DISC_LOW)
                 || (sample.humidity_sample >= HUM_DISC_HIGH)
                 || (sample.light_sample <= RAW_DISC_LOW)
                 || (sample.light_sample >= RAW_DISC_HIGH);
    // 10-bit raw channels can never exceed full scale
    assign oor_w = (sample.temperature_sample < TEMP_MIN)
                || (sample.temperature_sample > TEMP_MAX)
                || (sample.humidity_sample < HUM_MIN)
                || (sample.humidity_sample > HUM_MAX);

    assign full_w = (count_reg == CNT_W'(WINDOW_DEPTH));
    assign count_inc_w = full_w ? count_reg : count_reg + 1'b1;

    always_comb
    begin
        if (min_fill_reg == '0)
        begin
            need_w = CNT_W'(1);
        end
        else if (9'(min_fill_reg) > 9'(WINDOW_DEPTH))
        begin
            need_w = CNT_W'(WINDOW_DEPTH);
        end
        else
        begin
            need_w = CNT_W'(min_fill_reg);
        end
    end

    assign new_w.moisture    = x_reg[0][RAW_W-1:0];
    assign new_w.temperature = x_reg[1];
    assign new_w.humidity    = x_reg[2];
    assign new_w.light       = x_reg[3][RAW_W-1:0];

    zsa_window_mem u_mem
    (
        .clk     (clk),
        .wr_en   ((state_reg == ST_UPD) && (ch_reg == '0)),
        .wr_addr (write_slot_reg),
        .wr_data (new_w),
        .rd_en   (in_xfer),
        .rd_addr (write_slot_reg),
        .rd_data (old_w)
    );

    // evicted sample counts only once the window has wrapped
    always_comb
    begin
        case (ch_reg)
            2'd0:    old_ch_w = XW'({2'b0, old_w.moisture});
            2'd1:    old_ch_w = old_w.temperature;
            2'd2:    old_ch_w = old_w.humidity;
            default: old_ch_w = XW'({2'b0, old_w.light});
        endcase
        if (!full_w)
        begin
            old_ch_w = '0;
        end
    end

    assign x_ch_w = x_reg[ch_reg];
    assign dsum_w = DIFF_W'(x_ch_w) - DIFF_W'(old_ch_w);
    assign psum_w = DIFF_W'(x_ch_w) + DIFF_W'(old_ch_w);
    assign dq_w   = dsum_w * psum_w;

    zsa_ztest u_ztest
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (zstart_reg),
        .n     (count_reg),
        .x     (x_ch_w),
        .s     (sum_reg[ch_reg]),
        .q     (sq_reg[ch_reg]),
        .thr   (z_threshold_reg),
        .lim   (score_z_limit_reg),
        .res   (zres)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = (disc_w || oor_w) ? ST_DONE : ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (ch_reg == CH_W'(NUM_CH - 1))
                begin
                    state_next = (count_inc_w >= need_w) ? ST_CALC : ST_DONE;
                end
            end
            ST_CALC:
            begin
                if (zres.done && (ch_reg == CH_W'(NUM_CH - 1)))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            z_threshold_reg   <= Z_THRESHOLD_RST;
            score_z_limit_reg <= SCORE_Z_LIMIT_RST;
            min_fill_reg      <= MIN_FILL_RST;
            write_slot_reg    <= '0;
            count_reg         <= '0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                sum_reg[i] <= '0;
                sq_reg[i]  <= '0;
            end
            ch_reg        <= '0;
            zstart_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            enough_reg    <= 1'b0;
            an_reg        <= '0;
            comb_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_Z_THRESHOLD:   z_threshold_reg   <= cfg.data;
                    CFG_SCORE_Z_LIMIT: score_z_limit_reg <= cfg.data;
                    CFG_MIN_FILL:      min_fill_reg      <= cfg.data[MIN_W-1:0];
                    default:           ;
                endcase
            end

            if ((state_reg == ST_DONE) && (!out_valid_reg || result.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    zstart_reg <= 1'b0;
                    if (in_xfer)
                    begin
                        ch_reg     <= '0;
                        an_reg     <= '0;
                        comb_reg   <= 1'b0;
                        enough_reg <= (count_reg >= need_w);
                    end
                end
                ST_UPD:
                begin
                    sum_reg[ch_reg] <= sum_reg[ch_reg] + SUM_W'(dsum_w);
                    sq_reg[ch_reg]  <= sq_reg[ch_reg] + SQ_W'(dq_w);
                    ch_reg <= ch_reg + 1'b1;
                    zstart_reg <= (ch_reg == CH_W'(NUM_CH - 1)) && (count_inc_w >= need_w);
                    if (ch_reg == CH_W'(NUM_CH - 1))
                    begin
                        count_reg  <= count_inc_w;
                        enough_reg <= (count_inc_w >= need_w);
                        write_slot_reg <= (write_slot_reg == SLOT_W'(WINDOW_DEPTH - 1))
                                          ? '0 : write_slot_reg + 1'b1;
                    end
                end
                ST_CALC:
                begin
                    zstart_reg <= zres.done && (ch_reg != CH_W'(NUM_CH - 1));
                    if (zres.done)
                    begin
                        an_reg[ch_reg] <= zres.over_thr;
                        comb_reg <= comb_reg || zres.over_lim;
                        if (ch_reg != CH_W'(NUM_CH - 1))
                        begin
                            ch_reg <= ch_reg + 1'b1;
                        end
                    end
                end
                ST_DONE:
                begin
                    zstart_reg <= 1'b0;
                end
                default: zstart_reg <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            x_reg[0] <= XW'({2'b0, sample.moisture_sample});
            x_reg[1] <= sample.temperature_sample;
            x_reg[2] <= sample.humidity_sample;
            x_reg[3] <= XW'({2'b0, sample.light_sample});
            disc_reg <= disc_w;
            oor_reg  <= oor_w;
        end
        if ((state_reg == ST_DONE) && (!out_valid_reg || result.ready))
        begin
            out_reg.disconnected     <= disc_reg;
            out_reg.out_of_range     <= oor_reg;
            out_reg.accepted         <= !disc_reg && !oor_reg;
            out_reg.enough_data      <= enough_reg;
            out_reg.anomaly          <= an_reg;
            out_reg.combined_anomaly <= comb_reg;
            out_reg.sensor_fault     <= disc_reg || oor_reg || comb_reg;
        end
    end

    assign result.valid               = out_valid_reg;
    assign result.disconnected        = out_reg.disconnected;
    assign result.out_of_range        = out_reg.out_of_range;
    assign result.accepted            = out_reg.accepted;
    assign result.enough_data         = out_reg.enough_data;
    assign result.moisture_anomaly    = out_reg.anomaly[0];
    assign result.temperature_anomaly = out_reg.anomaly[1];
    assign result.humidity_anomaly    = out_reg.anomaly[2];
    assign result.light_anomaly       = out_reg.anomaly[3];
    assign result.combined_anomaly    = out_reg.combined_anomaly;
    assign result.sensor_fault        = out_reg.sensor_fault;

endmodule
